[src/led_command_register_parser_top_macros.svh]
// Assertion macros for the LED command register parser.
// LCRP_ASSERT checks a same-cycle implication, LCRP_ASSERT_NEXT a next-cycle one.
`ifndef LED_COMMAND_REGISTER_PARSER_TOP_MACROS_SVH
`define LED_COMMAND_REGISTER_PARSER_TOP_MACROS_SVH
`ifndef SYNTH
`define LCRP_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcrp assertion failed");
`define LCRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcrp assertion failed");
`else
`define LCRP_ASSERT(label, clk, rst_n, ante, cons)
`define LCRP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/lcrp_pkg.sv]
`timescale 1ns / 1ps

package lcrp_pkg;

  // Command bytes
  localparam logic [7:0] CMD_BRIGHTNESS = 8'h01;
  localparam logic [7:0] CMD_COLOUR     = 8'h02;
  localparam logic [7:0] CMD_MODE       = 8'h10;
  localparam logic [7:0] CMD_MANUAL     = 8'hFF & 8'h20;
  localparam logic [7:0] CMD_OFF        = 8'hFF;

  // Light modes
  localparam logic [2:0] MODE_OFF = 3'd0;
  localparam logic [2:0] MODE_MAX = 3'd4;

  // Frame positions
  localparam logic [2:0] POS_CMD   = 3'd0;
  localparam logic [2:0] POS_FIRST = 3'd1;
  localparam logic [2:0] POS_2     = 3'd2;
  localparam logic [2:0] POS_3     = 3'd3;
  localparam logic [2:0] POS_4     = 3'd4;

  // Item kinds
  localparam logic ITEM_BYTE = 1'b0;
  localparam logic ITEM_TICK = 1'b1;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic REG_GAP_TIMEOUT = 1'b0;
  localparam logic REG_PIXEL_COUNT = 1'b1;
  localparam logic [7:0] GAP_TIMEOUT_RST = 8'd100;
  localparam logic [7:0] PIXEL_COUNT_RST = 8'd34;

  // Reset values of the settings
  localparam logic [7:0] BRIGHTNESS_RST = 8'd255;
  localparam logic [7:0] COLOUR_RST     = 8'd255;

  typedef struct packed {
    logic [7:0] gap_timeout_ms;
    logic [7:0] pixel_count;
  } cfg_t;

endpackage

[src/lcrp_cfg.sv]
`timescale 1ns / 1ps

module lcrp_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lcrp_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [lcrp_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [lcrp_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output lcrp_pkg::cfg_t                      cfg_o
);

  logic [7:0] gap_timeout_q;
  logic [7:0] pixel_count_q;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Write a register on the access phase of a transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_timeout_q <= lcrp_pkg::GAP_TIMEOUT_RST;
      pixel_count_q <= lcrp_pkg::PIXEL_COUNT_RST;
    end else if (wr_en) begin
      if (reg_sel == lcrp_pkg::REG_GAP_TIMEOUT) begin
        gap_timeout_q <= pwdata[7:0];
      end else begin
        pixel_count_q <= pwdata[7:0];
      end
    end
  end

  // Return the selected register
  always_comb begin
    if (reg_sel == lcrp_pkg::REG_GAP_TIMEOUT) begin
      prdata = {{(lcrp_pkg::CFG_DATA_W-8){1'b0}}, gap_timeout_q};
    end else begin
      prdata = {{(lcrp_pkg::CFG_DATA_W-8){1'b0}}, pixel_count_q};
    end
  end

  assign cfg_o.gap_timeout_ms = gap_timeout_q;
  assign cfg_o.pixel_count    = pixel_count_q;

endmodule

[src/led_command_register_parser_top.sv]
`timescale 1ns / 1ps

// LED command register parser. Each input transfer is either a received bus
// byte or a one-millisecond tick, and each one yields exactly one result that
// shows the lighting settings after that item. Items are taken one per clock
// cycle unless stalled; the frame decode is one level of logic between the
// state registers and a single output register, so a result appears in the
// next cycle. The input stalls only while that output register is full and
// the output side stalls. Registers: gap_timeout_ms at address 0 and
// pixel_count at address 4, written and read over the APB-style port.

`include "led_command_register_parser_top_macros.svh"

module led_command_register_parser_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lcrp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [lcrp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [lcrp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [7:0]                      data_byte_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      target_brightness_o,
  output logic [7:0]                      solid_red_o,
  output logic [7:0]                      solid_green_o,
  output logic [7:0]                      solid_blue_o,
  output logic [2:0]                      light_mode_o,
  output logic                            pixel_write_o,
  output logic [7:0]                      pixel_index_o,
  output logic [7:0]                      pixel_red_o,
  output logic [7:0]                      pixel_green_o,
  output logic [7:0]                      pixel_blue_o,
  output logic [2:0]                      frame_position_o
);

  lcrp_pkg::cfg_t cfg;

  lcrp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Parser state
  logic [7:0] cmd_q,        cmd_d;
  logic [2:0] pos_q,        pos_d;
  logic [7:0] bright_q,     bright_d;
  logic [7:0] solid_q  [3];
  logic [7:0] solid_d  [3];
  logic [2:0] lmode_q,      lmode_d;
  logic [7:0] man_idx_q,    man_idx_d;
  logic [7:0] man_col_q [3];
  logic [7:0] man_col_d [3];
  logic [7:0] idle_q,       idle_d;
  logic       active_q,     active_d;
  logic       wr_d;
  logic [8:0] idle_next;

  // Output register
  logic       out_valid_q;
  logic       pixel_write_q;
  logic [7:0] bright_oq;
  logic [7:0] solid_oq [3];
  logic [2:0] lmode_oq;
  logic [7:0] man_idx_oq;
  logic [7:0] man_col_oq [3];
  logic [2:0] pos_oq;

  logic in_fire;
  logic out_fire;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign out_fire   = out_valid_q & ~out_stall_i;
  assign idle_next  = {1'b0, idle_q} + 9'd1;

  // Decode one item into the next settings
  always_comb begin
    cmd_d     = cmd_q;
    pos_d     = pos_q;
    bright_d  = bright_q;
    solid_d   = solid_q;
    lmode_d   = lmode_q;
    man_idx_d = man_idx_q;
    man_col_d = man_col_q;
    idle_d    = idle_q;
    active_d  = active_q;
    wr_d      = 1'b0;
    if (mode_i == lcrp_pkg::ITEM_BYTE) begin
      idle_d   = '0;
      active_d = 1'b1;
      if (pos_q == lcrp_pkg::POS_CMD) begin
        cmd_d = data_byte_i;
        pos_d = lcrp_pkg::POS_FIRST;
      end else begin
        pos_d = lcrp_pkg::POS_CMD;
        unique case (cmd_q)
          lcrp_pkg::CMD_BRIGHTNESS: begin
            bright_d = data_byte_i;
          end
          lcrp_pkg::CMD_COLOUR: begin
            if (pos_q == lcrp_pkg::POS_FIRST) solid_d[0] = data_byte_i;
            if (pos_q == lcrp_pkg::POS_2)     solid_d[1] = data_byte_i;
            if (pos_q == lcrp_pkg::POS_3)     solid_d[2] = data_byte_i;
            if (pos_q < lcrp_pkg::POS_3) pos_d = pos_q + 3'd1;
          end
          lcrp_pkg::CMD_MODE: begin
            if (data_byte_i <= {5'd0, lcrp_pkg::MODE_MAX}) lmode_d = data_byte_i[2:0];
          end
          lcrp_pkg::CMD_MANUAL: begin
            if (pos_q == lcrp_pkg::POS_FIRST && data_byte_i < cfg.pixel_count) begin
              man_idx_d = data_byte_i;
            end
            if (pos_q == lcrp_pkg::POS_2) man_col_d[0] = data_byte_i;
            if (pos_q == lcrp_pkg::POS_3) man_col_d[1] = data_byte_i;
            if (pos_q == lcrp_pkg::POS_4) man_col_d[2] = data_byte_i;
            if (pos_q >= lcrp_pkg::POS_4) begin
              wr_d = 1'b1;
            end else begin
              pos_d = pos_q + 3'd1;
            end
          end
          lcrp_pkg::CMD_OFF: begin
            lmode_d = lcrp_pkg::MODE_OFF;
          end
          default: begin
            pos_d = lcrp_pkg::POS_CMD;
          end
        endcase
      end
    end else if (active_q) begin
      // Count idle ticks; drop the partial frame past the timeout
      if (idle_next > {1'b0, cfg.gap_timeout_ms}) begin
        pos_d    = lcrp_pkg::POS_CMD;
        idle_d   = '0;
        active_d = 1'b0;
      end else begin
        idle_d = idle_next[7:0];
      end
    end
  end

  // Advance the parser state on an input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q        <= '0;
      pos_q        <= lcrp_pkg::POS_CMD;
      bright_q     <= lcrp_pkg::BRIGHTNESS_RST;
      solid_q[0]   <= lcrp_pkg::COLOUR_RST;
      solid_q[1]   <= lcrp_pkg::COLOUR_RST;
      solid_q[2]   <= lcrp_pkg::COLOUR_RST;
      lmode_q      <= lcrp_pkg::MODE_OFF;
      man_idx_q    <= '0;
      man_col_q[0] <= lcrp_pkg::COLOUR_RST;
      man_col_q[1] <= lcrp_pkg::COLOUR_RST;
      man_col_q[2] <= lcrp_pkg::COLOUR_RST;
      idle_q       <= '0;
      active_q     <= 1'b0;
    end else if (in_fire) begin
      cmd_q     <= cmd_d;
      pos_q     <= pos_d;
      bright_q  <= bright_d;
      solid_q   <= solid_d;
      lmode_q   <= lmode_d;
      man_idx_q <= man_idx_d;
      man_col_q <= man_col_d;
      idle_q    <= idle_d;
      active_q  <= active_d;
    end
  end

  // Hold the result valid until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pixel_write_q <= wr_d;
      bright_oq     <= bright_d;
      solid_oq      <= solid_d;
      lmode_oq      <= lmode_d;
      man_idx_oq    <= man_idx_d;
      man_col_oq    <= man_col_d;
      pos_oq        <= pos_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign target_brightness_o = bright_oq;
  assign solid_red_o         = solid_oq[0];
  assign solid_green_o       = solid_oq[1];
  assign solid_blue_o        = solid_oq[2];
  assign light_mode_o        = lmode_oq;
  assign pixel_write_o       = pixel_write_q;
  assign pixel_index_o       = man_idx_oq;
  assign pixel_red_o         = man_col_oq[0];
  assign pixel_green_o       = man_col_oq[1];
  assign pixel_blue_o        = man_col_oq[2];
  assign frame_position_o    = pos_oq;

  // Checks
  `LCRP_ASSERT_NEXT(a_in_gives_result, clk_i, rst_ni, in_fire, out_valid_q)
  `LCRP_ASSERT(a_write_ends_frame, clk_i, rst_ni, out_valid_q && pixel_write_q, pos_oq == lcrp_pkg::POS_CMD)
  `LCRP_ASSERT(a_mode_range, clk_i, rst_ni, out_valid_q, lmode_oq <= lcrp_pkg::MODE_MAX)

endmodule

[test/led_command_register_parser_top_tb.sv]
`timescale 1ns / 1ps

module led_command_register_parser_top_tb;

  // One result word: the lighting settings after an item
  typedef struct packed {
    logic [7:0] brightness;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [2:0] light_mode;
    logic       wr;
    logic [7:0] idx;
    logic [7:0] pix_red;
    logic [7:0] pix_green;
    logic [7:0] pix_blue;
    logic [2:0] pos;
  } led_result_t;

  // One row of the directed script
  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic        typed;
    led_result_t want;
  } script_row_t;

  localparam led_result_t AFTER_RESET = '{
    lcrp_pkg::BRIGHTNESS_RST, lcrp_pkg::COLOUR_RST, lcrp_pkg::COLOUR_RST, lcrp_pkg::COLOUR_RST,
    lcrp_pkg::MODE_OFF, 1'b0, 8'd0, lcrp_pkg::COLOUR_RST, lcrp_pkg::COLOUR_RST,
    lcrp_pkg::COLOUR_RST, lcrp_pkg::POS_CMD};
  localparam led_result_t ARMED       = '{
    lcrp_pkg::BRIGHTNESS_RST, lcrp_pkg::COLOUR_RST, lcrp_pkg::COLOUR_RST, lcrp_pkg::COLOUR_RST,
    lcrp_pkg::MODE_OFF, 1'b0, 8'd0, lcrp_pkg::COLOUR_RST, lcrp_pkg::COLOUR_RST,
    lcrp_pkg::COLOUR_RST, lcrp_pkg::POS_FIRST};
  localparam led_result_t DIMMED      = '{
    8'd0, lcrp_pkg::COLOUR_RST, lcrp_pkg::COLOUR_RST, lcrp_pkg::COLOUR_RST,
    lcrp_pkg::MODE_OFF, 1'b0, 8'd0, lcrp_pkg::COLOUR_RST, lcrp_pkg::COLOUR_RST,
    lcrp_pkg::COLOUR_RST, lcrp_pkg::POS_CMD};
  localparam led_result_t MANUAL_SET  = '{
    lcrp_pkg::BRIGHTNESS_RST, lcrp_pkg::COLOUR_RST, lcrp_pkg::COLOUR_RST, lcrp_pkg::COLOUR_RST,
    lcrp_pkg::MODE_MAX, 1'b0, 8'd0, lcrp_pkg::COLOUR_RST, lcrp_pkg::COLOUR_RST,
    lcrp_pkg::COLOUR_RST, lcrp_pkg::POS_CMD};
  localparam int N_SCRIPT = 27;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [lcrp_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [lcrp_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [lcrp_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic                            mode_i = lcrp_pkg::ITEM_BYTE;
  logic [7:0]                      data_byte_i = 8'd0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [7:0]                      target_brightness_o;
  logic [7:0]                      solid_red_o;
  logic [7:0]                      solid_green_o;
  logic [7:0]                      solid_blue_o;
  logic [2:0]                      light_mode_o;
  logic                            pixel_write_o;
  logic [7:0]                      pixel_index_o;
  logic [7:0]                      pixel_red_o;
  logic [7:0]                      pixel_green_o;
  logic [7:0]                      pixel_blue_o;
  logic [2:0]                      frame_position_o;

  // Typed expectation travels with the payload of a script row
  logic                  row_typed_q = 1'b0;
  led_result_t           row_want_q = AFTER_RESET;

  // Parser state mirror
  logic [7:0] gap_cfg = lcrp_pkg::GAP_TIMEOUT_RST;
  logic [7:0] count_cfg = lcrp_pkg::PIXEL_COUNT_RST;
  logic [7:0] cmd_sel = 8'd0;
  logic [2:0] frame_pos = lcrp_pkg::POS_CMD;
  logic [7:0] bright_goal = lcrp_pkg::BRIGHTNESS_RST;
  logic [7:0] solid_rgb [3] = '{lcrp_pkg::COLOUR_RST, lcrp_pkg::COLOUR_RST, lcrp_pkg::COLOUR_RST};
  logic [2:0] mode_q = lcrp_pkg::MODE_OFF;
  logic [7:0] man_idx = 8'd0;
  logic [7:0] man_rgb [3] = '{lcrp_pkg::COLOUR_RST, lcrp_pkg::COLOUR_RST, lcrp_pkg::COLOUR_RST};
  logic [7:0] idle_cnt = 8'd0;
  logic       live = 1'b0;

  led_result_t settings_q [$];
  int          err_count = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  script_row_t led_script [N_SCRIPT] = '{
    '{lcrp_pkg::ITEM_TICK, 8'h00,                    1'b1, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, lcrp_pkg::CMD_BRIGHTNESS, 1'b1, ARMED},
    '{lcrp_pkg::ITEM_BYTE, 8'h00,                    1'b1, DIMMED},
    '{lcrp_pkg::ITEM_BYTE, lcrp_pkg::CMD_BRIGHTNESS, 1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, 8'hFF,                    1'b1, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, lcrp_pkg::CMD_MODE,       1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, 8'h05,                    1'b1, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, lcrp_pkg::CMD_MODE,       1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, 8'h04,                    1'b1, MANUAL_SET},
    '{lcrp_pkg::ITEM_BYTE, lcrp_pkg::CMD_COLOUR,     1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, 8'h00,                    1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, 8'h80,                    1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, 8'hFF,                    1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, lcrp_pkg::CMD_MANUAL,     1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, 8'd33,                    1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, 8'h00,                    1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, 8'hFF,                    1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, 8'h7F,                    1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, lcrp_pkg::CMD_MANUAL,     1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, 8'd34,                    1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, 8'h01,                    1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, 8'h02,                    1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, 8'h03,                    1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, lcrp_pkg::CMD_OFF,        1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, 8'hA5,                    1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, 8'h5A,                    1'b0, AFTER_RESET},
    '{lcrp_pkg::ITEM_BYTE, 8'hFF,                    1'b0, AFTER_RESET}
  };

  led_command_register_parser_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .data_byte_i        (data_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .target_brightness_o(target_brightness_o),
    .solid_red_o        (solid_red_o),
    .solid_green_o      (solid_green_o),
    .solid_blue_o       (solid_blue_o),
    .light_mode_o       (light_mode_o),
    .pixel_write_o      (pixel_write_o),
    .pixel_index_o      (pixel_index_o),
    .pixel_red_o        (pixel_red_o),
    .pixel_green_o      (pixel_green_o),
    .pixel_blue_o       (pixel_blue_o),
    .frame_position_o   (frame_position_o)
  );

  always #5 clk_i = ~clk_i;

  // Advance the parser mirror by one item and return the settings after it
  function automatic led_result_t apply_item(input logic kind, input logic [7:0] b);
    led_result_t res;
    logic        wr;
    wr = 1'b0;
    if (kind == lcrp_pkg::ITEM_BYTE) begin
      idle_cnt = 8'd0;
      live = 1'b1;
      if (frame_pos == lcrp_pkg::POS_CMD) begin
        cmd_sel = b;
        frame_pos = lcrp_pkg::POS_FIRST;
      end else begin
        case (cmd_sel)
          lcrp_pkg::CMD_BRIGHTNESS: begin
            bright_goal = b;
            frame_pos = lcrp_pkg::POS_CMD;
          end
          lcrp_pkg::CMD_COLOUR: begin
            if (frame_pos >= lcrp_pkg::POS_FIRST && frame_pos <= lcrp_pkg::POS_3) begin
              solid_rgb[frame_pos - lcrp_pkg::POS_FIRST] = b;
            end
            frame_pos = (frame_pos < lcrp_pkg::POS_3) ? frame_pos + 3'd1 : lcrp_pkg::POS_CMD;
          end
          lcrp_pkg::CMD_MODE: begin
            if (b <= {5'd0, lcrp_pkg::MODE_MAX}) mode_q = b[2:0];
            frame_pos = lcrp_pkg::POS_CMD;
          end
          lcrp_pkg::CMD_MANUAL: begin
            // an index at or above the pixel count keeps the old one
            if (frame_pos == lcrp_pkg::POS_FIRST && b < count_cfg) man_idx = b;
            if (frame_pos >= lcrp_pkg::POS_2 && frame_pos <= lcrp_pkg::POS_4) begin
              man_rgb[frame_pos - lcrp_pkg::POS_2] = b;
            end
            if (frame_pos >= lcrp_pkg::POS_4) begin
              wr = 1'b1;
              frame_pos = lcrp_pkg::POS_CMD;
            end else begin
              frame_pos = frame_pos + 3'd1;
            end
          end
          lcrp_pkg::CMD_OFF: begin
            mode_q = lcrp_pkg::MODE_OFF;
            frame_pos = lcrp_pkg::POS_CMD;
          end
          default: frame_pos = lcrp_pkg::POS_CMD;
        endcase
      end
    end else if (live) begin
      // abandon the frame once the silence outlasts the timeout
      if ({1'b0, idle_cnt} + 9'd1 > {1'b0, gap_cfg}) begin
        frame_pos = lcrp_pkg::POS_CMD;
        idle_cnt = 8'd0;
        live = 1'b0;
      end else begin
        idle_cnt = idle_cnt + 8'd1;
      end
    end
    res.brightness = bright_goal;
    res.red        = solid_rgb[0];
    res.green      = solid_rgb[1];
    res.blue       = solid_rgb[2];
    res.light_mode = mode_q;
    res.wr         = wr;
    res.idx        = man_idx;
    res.pix_red    = man_rgb[0];
    res.pix_green  = man_rgb[1];
    res.pix_blue   = man_rgb[2];
    res.pos        = frame_pos;
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  // Predict on every input transfer, then compare every output transfer
  always @(posedge clk_i) begin
    led_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want = apply_item(mode_i, data_byte_i);
        settings_q.push_back(row_typed_q ? row_want_q : want);
      end
      if (out_valid_o && !out_stall_i) begin
        if (settings_q.size() == 0) begin
          $error("result transfer with no expected settings pending");
          err_count++;
        end else begin
          want = settings_q.pop_front();
          check_field("target_brightness", want.brightness, target_brightness_o);
          check_field("solid_red", want.red, solid_red_o);
          check_field("solid_green", want.green, solid_green_o);
          check_field("solid_blue", want.blue, solid_blue_o);
          check_field("light_mode", want.light_mode, light_mode_o);
          check_field("pixel_write", want.wr, pixel_write_o);
          check_field("pixel_index", want.idx, pixel_index_o);
          check_field("pixel_red", want.pix_red, pixel_red_o);
          check_field("pixel_green", want.pix_green, pixel_green_o);
          check_field("pixel_blue", want.pix_blue, pixel_blue_o);
          check_field("frame_position", want.pos, frame_position_o);
        end
      end
    end
  end

  // Random receiver stall
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // Offer one item after a random gap and hold it until transfer
  task automatic push_item(input logic kind, input logic [7:0] b,
                           input logic typed = 1'b0, input led_result_t want = AFTER_RESET);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= kind;
    data_byte_i <= b;
    row_typed_q <= typed;
    row_want_q  <= want;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Hold off the sender until every expected result has come
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (settings_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == lcrp_pkg::REG_GAP_TIMEOUT) gap_cfg = val;
    else count_cfg = val;
  endtask

  task automatic set_regs(input logic [7:0] gap, input logic [7:0] count);
    write_reg(lcrp_pkg::REG_GAP_TIMEOUT, gap);
    write_reg(lcrp_pkg::REG_PIXEL_COUNT, count);
    @(posedge clk_i);
  endtask

  // Send ticks around the timeout so frames both survive and get abandoned
  task automatic tick_burst();
    int n;
    case ($urandom_range(3))
      0:       n = $urandom_range(1, 3);
      1:       n = gap_cfg;
      2:       n = gap_cfg + 1;
      default: n = $urandom_range(0, gap_cfg + 2);
    endcase
    repeat (n) push_item(lcrp_pkg::ITEM_TICK, rand_byte());
  endtask

  // Pick a data byte that lands near the interesting boundaries
  function automatic logic [7:0] frame_byte(input logic [7:0] cmd, input int slot);
    if (cmd == lcrp_pkg::CMD_MODE && $urandom_range(3) != 0) return 8'($urandom_range(7));
    if (cmd == lcrp_pkg::CMD_MANUAL && slot == 1) begin
      case ($urandom_range(3))
        0: return count_cfg - 8'd1;
        1: return count_cfg;
        2: return 8'd0;
        default: return rand_byte();
      endcase
    end
    return rand_byte();
  endfunction

  task automatic send_frame();
    logic [7:0] cmd;
    int         len;
    int         stop;
    case ($urandom_range(5))
      0:       cmd = lcrp_pkg::CMD_BRIGHTNESS;
      1:       cmd = lcrp_pkg::CMD_COLOUR;
      2:       cmd = lcrp_pkg::CMD_MODE;
      3:       cmd = lcrp_pkg::CMD_MANUAL;
      4:       cmd = lcrp_pkg::CMD_OFF;
      default: cmd = rand_byte();
    endcase
    len = (cmd == lcrp_pkg::CMD_COLOUR) ? 3 : (cmd == lcrp_pkg::CMD_MANUAL) ? 4 : 1;
    // cut some frames short so the timeout gets to abandon them
    stop = ($urandom_range(99) < 15) ? $urandom_range(len - 1) : len;
    push_item(lcrp_pkg::ITEM_BYTE, cmd);
    for (int i = 1; i <= stop; i++) begin
      if ($urandom_range(99) < 8) tick_burst();
      push_item(lcrp_pkg::ITEM_BYTE, frame_byte(cmd, i));
    end
    if (stop < len || $urandom_range(99) < 20) tick_burst();
  endtask

  task automatic run_random(input int n_items, input bit pause_midway);
    int start;
    bit paused;
    start  = items_sent;
    paused = 1'b0;
    while (items_sent - start < n_items) begin
      if (pause_midway && !paused && items_sent - start >= n_items / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 10) push_item(1'($urandom_range(1)), rand_byte());
      else send_frame();
    end
    drain();
  endtask

  // Stimulus
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed script on reset settings, no idling
    foreach (led_script[i])
      push_item(led_script[i].kind, led_script[i].data, led_script[i].typed, led_script[i].want);
    drain();

    set_regs(8'd255, 8'd255);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(220, 1'b0);

    set_regs(8'd0, 8'd1);
    send_idle_pct = 62;
    recv_stall_pct = 0;
    run_random(220, 1'b0);

    set_regs(8'd1, 8'd0);
    send_idle_pct = 0;
    recv_stall_pct = 62;
    run_random(220, 1'b0);

    set_regs(8'($urandom_range(2, 20)), rand_byte());
    send_idle_pct = 20;
    recv_stall_pct = 20;
    run_random(220, 1'b0);

    set_regs(8'd3, lcrp_pkg::PIXEL_COUNT_RST);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(220, 1'b1);

    repeat (4) @(posedge clk_i);
    if (err_count == 0) begin
      $display("led_command_register_parser_top_tb OK");
    end else begin
      $display("led_command_register_parser_top_tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("led_command_register_parser_top_tb NOT OK");
    $finish;
  end

endmodule
